// ===== design/luf_pkg.sv =====
// Shared types, constants and byte classification for the lenient UTF-8 decoder.
// No dependencies.
package luf_pkg;

    localparam int MAX_SEQ_BYTES   = 6;
    localparam int LUF_QUEUE_DEPTH = 2;
    localparam int SEQ_CNT_W       = $clog2(MAX_SEQ_BYTES + 1);
    localparam int CP_W            = 31;

    localparam logic [7:0] PLAIN_LIMIT = 8'd127;
    localparam logic [7:0] CONT_MASK   = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] ncont;
        logic       plain;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] ncont;
        logic       plain;
    } t_entry;

    function automatic logic [2:0] cont_count(input logic [7:0] b);
        logic [2:0] n;
        if (b >= 8'hfc) begin
            n = 3'd5;
        end else if (b >= 8'hf8) begin
            n = 3'd4;
        end else if (b >= 8'hf0) begin
            n = 3'd3;
        end else if (b >= 8'he0) begin
            n = 3'd2;
        end else if (b >= 8'hc0) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic logic [7:0] lead_mask(input logic [2:0] n);
        logic [7:0] m;
        case (n)
            3'd1:    m = 8'hc0;
            3'd2:    m = 8'he0;
            3'd3:    m = 8'hf0;
            3'd4:    m = 8'hf8;
            default: m = 8'hfc;
        endcase
        return m;
    endfunction

endpackage

// ===== design/lenient_utf8_decoder.sv =====
// Top level of the lenient UTF-8 to code point decoder: front, queue, back.
// Depends on luf_pkg, luf_front, luf_queue, luf_back.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_in_byte[7:0], i_in_last
//   out      source     o_out_valid / i_out_stall  o_code_point[30:0], o_out_last
//
// Each byte is loaded into the window buffer, then the window is scanned
// step by step. A scan step emits a code point, drops a rejected lead, or finds
// the window still open. A rejected window drops its lead and rescans the
// bytes behind it, one dropped lead or replayed code point per step. A last
// byte also yields a terminating result. The scan sequencer in the back stage,
// one step per cycle while the output is not stalled, sets the rate.
// Reset is synchronous and clears the window, queue and output valid.
// An output stall holds the scan; the queue and front register then fill and stall the input.
module lenient_utf8_decoder #(
    parameter int QUEUE_DEPTH = luf_pkg::LUF_QUEUE_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [7:0]               i_in_byte,
    input  logic                     i_in_last,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [luf_pkg::CP_W-1:0] o_code_point,
    output logic                     o_out_last
);
    import luf_pkg::*;

    logic  f_valid;
    t_item f_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    luf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (f_valid),
        .o_item     (f_item),
        .i_full     (q_full)
    );

    luf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    luf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_code_point (o_code_point),
        .o_out_last   (o_out_last)
    );

endmodule

// ===== design/luf_front.sv =====
// Input stage: takes byte transfers and classifies each byte (lead count, plain).
// Depends on luf_pkg.
module luf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    output logic          o_valid,
    output luf_pkg::t_item o_item,
    input  logic          i_full
);
    import luf_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  take;
    logic  push;

    assign push       = r_valid && !i_full;
    assign o_in_stall = r_valid && i_full;
    assign take       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.data  <= i_in_byte;
            r_item.ncont <= cont_count(i_in_byte);
            r_item.plain <= (i_in_byte < PLAIN_LIMIT) || (cont_count(i_in_byte) == 3'd0);
            r_item.last  <= i_in_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== design/luf_queue.sv =====
// Short FIFO of classified bytes between the front and back stages.
// Depends on luf_pkg.
module luf_queue #(
    parameter int DEPTH = luf_pkg::LUF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  luf_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output luf_pkg::t_item o_item
);
    import luf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

// ===== design/luf_back.sv =====
// Decode stage: pending window buffer, scan sequencer and output register.
// Depends on luf_pkg.
module luf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  luf_pkg::t_item             i_item,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [luf_pkg::CP_W-1:0]   o_code_point,
    output logic                       o_out_last
);
    import luf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TERM = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [SEQ_CNT_W-1:0] r_count, n_count;
    logic                 r_last,  n_last;
    t_entry               r_pend [MAX_SEQ_BYTES];
    t_entry               n_pend [MAX_SEQ_BYTES];

    logic                 r_out_valid;
    logic [CP_W-1:0]      r_cp;
    logic                 r_olast;

    logic                 out_free;
    logic                 emit;
    logic [CP_W-1:0]      em_cp;
    logic                 em_last;
    logic [SEQ_CNT_W-1:0] drop_k;
    logic [SEQ_CNT_W-1:0] rem;
    logic                 win_ok;
    logic                 bad;
    logic [31:0]          cp_full;
    logic [7:0]           lead_part;
    t_entry               lead;

    assign out_free = !r_out_valid || !i_out_stall;
    assign lead     = r_pend[0];
    assign win_ok   = r_count >= (SEQ_CNT_W'(lead.ncont) + 1'b1);

    always_comb begin
        bad       = 1'b0;
        cp_full   = '0;
        lead_part = lead.data & ~lead_mask(lead.ncont);
        for (int i = 1; i < MAX_SEQ_BYTES; i++) begin
            if (3'(i) <= lead.ncont && r_pend[i].data < PLAIN_LIMIT) begin
                bad = 1'b1;
            end
        end
        for (int m = 1; m < MAX_SEQ_BYTES; m++) begin
            if (lead.ncont == 3'(m)) begin
                cp_full = {24'd0, lead_part} << (6 * m);
                for (int i = 1; i <= m; i++) begin
                    cp_full = cp_full |
                        ({24'd0, r_pend[i].data & ~CONT_MASK} << (6 * (m - i)));
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_last  = r_last;
        n_pend  = r_pend;
        emit    = 1'b0;
        em_cp   = '0;
        em_last = 1'b0;
        o_pop   = 1'b0;
        drop_k  = '0;
        rem     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_last  = i_item.last;
                    n_state = S_SCAN;
                    if (r_count < SEQ_CNT_W'(MAX_SEQ_BYTES)) begin
                        for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
                            if (r_count == SEQ_CNT_W'(i)) begin
                                n_pend[i] = '{data: i_item.data, ncont: i_item.ncont,
                                              plain: i_item.plain};
                            end
                        end
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (r_count == '0 || (!lead.plain && !win_ok)) begin
                    n_state = r_last ? S_TERM : S_IDLE;
                end else if (lead.plain) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        em_cp  = CP_W'(lead.data);
                        drop_k = SEQ_CNT_W'(1);
                    end
                end else if (bad) begin
                    drop_k = SEQ_CNT_W'(1);
                end else if (out_free) begin
                    emit   = 1'b1;
                    em_cp  = cp_full[CP_W-1:0];
                    drop_k = SEQ_CNT_W'(lead.ncont) + 1'b1;
                end
                if (drop_k != '0) begin
                    rem = (drop_k < r_count) ? r_count - drop_k : '0;
                    for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
                        for (int j = 1; j <= MAX_SEQ_BYTES; j++) begin
                            if (drop_k == SEQ_CNT_W'(j) && i + j < MAX_SEQ_BYTES) begin
                                n_pend[i] = r_pend[i + j];
                            end
                        end
                    end
                    n_count = rem;
                    if (rem == '0) begin
                        n_state = r_last ? S_TERM : S_IDLE;
                    end
                end
            end
            S_TERM: begin
                if (out_free) begin
                    emit    = 1'b1;
                    em_last = 1'b1;
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_last  <= n_last;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (emit) begin
            r_cp    <= em_cp;
            r_olast <= em_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_cp;
    assign o_out_last   = r_olast;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SEQ_CNT_W'(MAX_SEQ_BYTES))
        else $error("pending count out of range");

    a_idle_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_count < SEQ_CNT_W'(MAX_SEQ_BYTES))
        else $error("pending buffer full while idle");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM && out_free) |=> (r_count == '0 && o_out_valid && o_out_last))
        else $error("terminator did not clear pending window");

    a_term_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TERM |-> r_last)
        else $error("terminator without last byte");

endmodule
